@@ src/cau_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, codes and helpers of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

	localparam int FRAC_BITS_DEF = 8;
	// quotient bits resolved by the divider chain; larger quotients saturate anyway
	localparam int QBITS = 17;
	// width of product sums and of the divider remainder
	localparam int PW = 33;
	localparam int RW = 33;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_SAT  = 2'd1;
	localparam logic [1:0] ST_DIVZ = 2'd2;

	localparam logic signed [PW-1:0] S16_MAX = 33'sd32767;
	localparam logic signed [PW-1:0] S16_MIN = -33'sd32768;

	typedef struct packed {
		op_t         op;
		logic        zero;
		logic        neg_re;
		logic        neg_im;
		logic        big_re;
		logic        big_im;
		logic [15:0] res_re;
		logic [15:0] res_im;
		logic [1:0]  status;
	} meta_t;

	typedef struct packed {
		logic [15:0] v;
		logic        s;
	} sat_t;

	function automatic sat_t sat16(input logic signed [PW-1:0] x);
		sat_t r;
		r.s = 1'b0;
		r.v = x[15:0];
		if (x > S16_MAX) begin
			r.v = 16'h7FFF;
			r.s = 1'b1;
		end else if (x < S16_MIN) begin
			r.v = 16'h8000;
			r.s = 1'b1;
		end
		return r;
	endfunction

endpackage

@@ src/cau_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_req_if
// Request channel: operation code and two complex Q8.8 operands.
// ----------------------------------------------------------------------------
interface cau_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic signed [15:0] a_re;
	logic signed [15:0] a_im;
	logic signed [15:0] b_re;
	logic signed [15:0] b_im;

	modport source(output valid, req_type, a_re, a_im, b_re, b_im, input ready);
	modport sink(input valid, req_type, a_re, a_im, b_re, b_im, output ready);
endinterface

@@ src/cau_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_rsp_if
// Response channel: complex Q8.8 result and status.
// ----------------------------------------------------------------------------
interface cau_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] res_re;
	logic signed [15:0] res_im;
	logic [1:0]         status;

	modport source(output valid, res_re, res_im, status, input ready);
	modport sink(input valid, res_re, res_im, status, output ready);
endinterface

@@ src/complex_arithmetic_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Pipelined complex add, subtract, multiply and divide in signed Q8.8.
// ----------------------------------------------------------------------------
// Usage:
//   req carries req_type (add, subtract, multiply, divide) and operands A, B.
//   rsp returns res_re, res_im and status (ok, saturated, divide by zero).
//   A transfer happens on a clock edge where valid and ready are both high.
// Pipeline: 21 register stages: two stages of products and sums, one stage
//   of magnitude and range check, 17 division cells (one quotient bit each),
//   and the output register. Add, subtract and multiply results ride along
//   the same pipe so order is kept.
// Throughput: one item per cycle while the output is not stalled. The divider
//   is a chain of cells, each resolving one quotient bit for both parts, so a
//   new item enters each cycle unless the pipe is stalled.
// Stall: while a result waits in the output register and rsp.ready is low,
//   the whole pipe holds and req.ready drops; items already inside are kept.
// Reset: arst_n clears all valid bits; no result is pending after reset.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit #(
	parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
	input logic      clk,
	input logic      arst_n,
	cau_req_if.sink  req,
	cau_rsp_if.source rsp
);
	localparam int PW = cau_pkg::PW;
	localparam int RW = cau_pkg::RW;
	localparam int QB = cau_pkg::QBITS;
	localparam int NW = 32 + FRAC_BITS;

	logic en;
	logic out_valid_q;

	// advance everything unless a finished result is stuck at the output
	assign en        = !(out_valid_q && !rsp.ready);
	assign req.ready = en;

	// product and sum stages
	logic                 valid_s2;
	cau_pkg::meta_t       meta_s2;
	logic signed [PW-1:0] dre_s2, dim_s2;
	logic [31:0]          den_s2;

	cau_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid    (req.valid && req.ready),
		.req_type (req.req_type),
		.a_re     (req.a_re),
		.a_im     (req.a_im),
		.b_re     (req.b_re),
		.b_im     (req.b_im),
		.valid_s2 (valid_s2),
		.meta_s2  (meta_s2),
		.dre_s2   (dre_s2),
		.dim_s2   (dim_s2),
		.den_s2   (den_s2)
	);

	// head of the division chain: take magnitudes, scale, check quotient range
	logic [31:0]    mag_re, mag_im;
	logic [NW-1:0]  n_re, n_im;
	logic           big_re, big_im;
	cau_pkg::meta_t meta_head;

	always_comb begin
		mag_re = dre_s2[PW-1] ? 32'(-dre_s2) : dre_s2[31:0];
		mag_im = dim_s2[PW-1] ? 32'(-dim_s2) : dim_s2[31:0];
		n_re   = NW'(mag_re) << FRAC_BITS;
		n_im   = NW'(mag_im) << FRAC_BITS;
		// quotient would need more than QB bits
		big_re = (n_re >> QB) >= NW'(den_s2);
		big_im = (n_im >> QB) >= NW'(den_s2);
		meta_head        = meta_s2;
		meta_head.zero   = (den_s2 == 32'd0);
		meta_head.neg_re = dre_s2[PW-1];
		meta_head.neg_im = dim_s2[PW-1];
		meta_head.big_re = big_re;
		meta_head.big_im = big_im;
	end

	logic           valid_c [0:QB];
	cau_pkg::meta_t meta_c  [0:QB];
	logic [RW-1:0]  rem_re_c [0:QB];
	logic [RW-1:0]  rem_im_c [0:QB];
	logic [NW-1:0]  n_re_c  [0:QB];
	logic [NW-1:0]  n_im_c  [0:QB];
	logic [QB-1:0]  q_re_c  [0:QB];
	logic [QB-1:0]  q_im_c  [0:QB];
	logic [31:0]    den_c   [0:QB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_c[0] <= 1'b0;
		end else if (en) begin
			valid_c[0] <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_c[0]   <= meta_head;
			// only meaningful when the quotient fits, then it is below den
			rem_re_c[0] <= RW'(n_re >> QB);
			rem_im_c[0] <= RW'(n_im >> QB);
			n_re_c[0]   <= n_re;
			n_im_c[0]   <= n_im;
			q_re_c[0]   <= '0;
			q_im_c[0]   <= '0;
			den_c[0]    <= den_s2;
		end
	end

	// one cell per quotient bit, most significant first
	for (genvar k = 0; k < QB; k++) begin : g_cell
		cau_div_cell #(.NW(NW), .BIT(QB - 1 - k)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.valid_in  (valid_c[k]),
			.meta_in   (meta_c[k]),
			.rem_re_in (rem_re_c[k]),
			.rem_im_in (rem_im_c[k]),
			.n_re_in   (n_re_c[k]),
			.n_im_in   (n_im_c[k]),
			.q_re_in   (q_re_c[k]),
			.q_im_in   (q_im_c[k]),
			.den_in    (den_c[k]),
			.valid_q   (valid_c[k+1]),
			.meta_q    (meta_c[k+1]),
			.rem_re_q  (rem_re_c[k+1]),
			.rem_im_q  (rem_im_c[k+1]),
			.n_re_q    (n_re_c[k+1]),
			.n_im_q    (n_im_c[k+1]),
			.q_re_q    (q_re_c[k+1]),
			.q_im_q    (q_im_c[k+1]),
			.den_q     (den_c[k+1])
		);
	end

	// finish: apply sign, saturate, pick the divide or pass-through result
	cau_pkg::meta_t m;
	logic [QB-1:0]  qr, qi;
	logic           sat_re, sat_im;
	logic [15:0]    fin_re, fin_im;
	logic [1:0]     fin_st;

	always_comb begin
		m      = meta_c[QB];
		qr     = q_re_c[QB];
		qi     = q_im_c[QB];
		sat_re = m.big_re || (m.neg_re ? (qr > QB'(32768)) : (qr > QB'(32767)));
		sat_im = m.big_im || (m.neg_im ? (qi > QB'(32768)) : (qi > QB'(32767)));
		fin_re = m.res_re;
		fin_im = m.res_im;
		fin_st = m.status;
		if (m.op == cau_pkg::OP_DIV) begin
			if (m.zero) begin
				fin_re = '0;
				fin_im = '0;
				fin_st = cau_pkg::ST_DIVZ;
			end else begin
				if (sat_re)
					fin_re = m.neg_re ? 16'h8000 : 16'h7FFF;
				else
					fin_re = m.neg_re ? 16'(-qr) : qr[15:0];
				if (sat_im)
					fin_im = m.neg_im ? 16'h8000 : 16'h7FFF;
				else
					fin_im = m.neg_im ? 16'(-qi) : qi[15:0];
				fin_st = (sat_re || sat_im) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
			end
		end
	end

	logic [15:0] out_re_q, out_im_q;
	logic [1:0]  out_st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_c[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_re_q <= fin_re;
			out_im_q <= fin_im;
			out_st_q <= fin_st;
		end
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.res_re = out_re_q;
	assign rsp.res_im = out_im_q;
	assign rsp.status = out_st_q;

	// a divide-by-zero result carries zero parts
	a_divz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_st_q == cau_pkg::ST_DIVZ |-> out_re_q == '0 && out_im_q == '0)
		else $error("divide by zero result not cleared");

	// a saturated result has at least one part at a rail
	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_st_q == cau_pkg::ST_SAT |->
		out_re_q == 16'h7FFF || out_re_q == 16'h8000 ||
		out_im_q == 16'h7FFF || out_im_q == 16'h8000)
		else $error("saturation status without a saturated part");

	// an accepted request enters the division chain after the product stages
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && en |=> valid_c[0])
		else $error("item lost between product and division stages");

	// a stalled output holds its result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !rsp.ready |=> out_valid_q && $stable(out_re_q) && $stable(out_st_q))
		else $error("stalled result changed");
endmodule

@@ src/cau_prep.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_prep
// Two stages: partial products, then sums and add/sub/multiply results.
// ----------------------------------------------------------------------------
module cau_prep #(
	parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             valid,
	input  logic [1:0]                       req_type,
	input  logic signed [15:0]               a_re,
	input  logic signed [15:0]               a_im,
	input  logic signed [15:0]               b_re,
	input  logic signed [15:0]               b_im,
	output logic                             valid_s2,
	output cau_pkg::meta_t                   meta_s2,
	output logic signed [cau_pkg::PW-1:0]    dre_s2,
	output logic signed [cau_pkg::PW-1:0]    dim_s2,
	output logic [31:0]                      den_s2
);
	localparam int PW = cau_pkg::PW;

	logic               valid_s1;
	cau_pkg::op_t       op_s1;
	logic signed [31:0] rr_s1, ii_s1, ri_s1, ir_s1, bb_s1, cc_s1;
	logic signed [16:0] as_re_s1, as_im_s1;

	logic signed [PW-1:0] rr, ii, ri, ir, mre, mim, are, aim;
	cau_pkg::sat_t        sre, sim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= cau_pkg::op_t'(req_type);
			rr_s1 <= a_re * b_re;
			ii_s1 <= a_im * b_im;
			ri_s1 <= a_re * b_im;
			ir_s1 <= a_im * b_re;
			bb_s1 <= b_re * b_re;
			cc_s1 <= b_im * b_im;
			if (cau_pkg::op_t'(req_type) == cau_pkg::OP_SUB) begin
				as_re_s1 <= 17'(a_re) - 17'(b_re);
				as_im_s1 <= 17'(a_im) - 17'(b_im);
			end else begin
				as_re_s1 <= 17'(a_re) + 17'(b_re);
				as_im_s1 <= 17'(a_im) + 17'(b_im);
			end
		end
	end

	always_comb begin
		rr  = {rr_s1[31], rr_s1};
		ii  = {ii_s1[31], ii_s1};
		ri  = {ri_s1[31], ri_s1};
		ir  = {ir_s1[31], ir_s1};
		mre = (rr - ii) >>> FRAC_BITS;
		mim = (ri + ir) >>> FRAC_BITS;
		are = {{(PW-17){as_re_s1[16]}}, as_re_s1};
		aim = {{(PW-17){as_im_s1[16]}}, as_im_s1};
		if (op_s1 == cau_pkg::OP_MUL) begin
			sre = cau_pkg::sat16(mre);
			sim = cau_pkg::sat16(mim);
		end else begin
			sre = cau_pkg::sat16(are);
			sim = cau_pkg::sat16(aim);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s2.op     <= op_s1;
			meta_s2.zero   <= 1'b0;
			meta_s2.neg_re <= 1'b0;
			meta_s2.neg_im <= 1'b0;
			meta_s2.big_re <= 1'b0;
			meta_s2.big_im <= 1'b0;
			meta_s2.res_re <= sre.v;
			meta_s2.res_im <= sim.v;
			meta_s2.status <= (sre.s || sim.s) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
			dre_s2         <= rr + ii;
			dim_s2         <= ir - ri;
			den_s2         <= 32'(bb_s1) + 32'(cc_s1);
		end
	end
endmodule

@@ src/cau_div_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_div_cell
// One restoring-division cell: resolve one quotient bit for both lanes.
// ----------------------------------------------------------------------------
module cau_div_cell #(
	parameter int NW  = 40,
	parameter int BIT = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        valid_in,
	input  cau_pkg::meta_t              meta_in,
	input  logic [cau_pkg::RW-1:0]      rem_re_in,
	input  logic [cau_pkg::RW-1:0]      rem_im_in,
	input  logic [NW-1:0]               n_re_in,
	input  logic [NW-1:0]               n_im_in,
	input  logic [cau_pkg::QBITS-1:0]   q_re_in,
	input  logic [cau_pkg::QBITS-1:0]   q_im_in,
	input  logic [31:0]                 den_in,
	output logic                        valid_q,
	output cau_pkg::meta_t              meta_q,
	output logic [cau_pkg::RW-1:0]      rem_re_q,
	output logic [cau_pkg::RW-1:0]      rem_im_q,
	output logic [NW-1:0]               n_re_q,
	output logic [NW-1:0]               n_im_q,
	output logic [cau_pkg::QBITS-1:0]   q_re_q,
	output logic [cau_pkg::QBITS-1:0]   q_im_q,
	output logic [31:0]                 den_q
);
	localparam int RW = cau_pkg::RW;
	localparam int QB = cau_pkg::QBITS;

	logic [RW-1:0] t_re, t_im, d;
	logic          ge_re, ge_im;

	always_comb begin
		d     = RW'(den_in);
		t_re  = {rem_re_in[RW-2:0], n_re_in[BIT]};
		t_im  = {rem_im_in[RW-2:0], n_im_in[BIT]};
		ge_re = t_re >= d;
		ge_im = t_im >= d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_q   <= meta_in;
			n_re_q   <= n_re_in;
			n_im_q   <= n_im_in;
			den_q    <= den_in;
			rem_re_q <= ge_re ? t_re - d : t_re;
			rem_im_q <= ge_im ? t_im - d : t_im;
			q_re_q   <= {q_re_in[QB-2:0], ge_re};
			q_im_q   <= {q_im_in[QB-2:0], ge_im};
		end
	end
endmodule
